@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/core/vcsp_pkg.sv @@
// Types, codes and the silencing table of the VGM command stream player.
package vcsp_pkg;

    typedef enum logic [2:0] {
        CMD_BYTE    = 3'd0,
        CMD_TICK    = 3'd1,
        CMD_START   = 3'd2,
        CMD_STOP    = 3'd3,
        CMD_ENABLE  = 3'd4,
        CMD_DISABLE = 3'd5,
        CMD_EOD     = 3'd6
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_TONE   = 2'd1,
        KIND_FM     = 2'd2,
        KIND_REWIND = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic        port;
        logic [7:0]  rd;
        logic [7:0]  wv;
    } res_t;

    localparam logic [7:0]  OP_TONE     = 8'h50;
    localparam logic [7:0]  OP_FM0      = 8'h52;
    localparam logic [7:0]  OP_FM1      = 8'h53;
    localparam logic [7:0]  OP_WAIT     = 8'h61;
    localparam logic [7:0]  OP_WAIT_NTSC = 8'h62;
    localparam logic [7:0]  OP_WAIT_PAL = 8'h63;
    localparam logic [7:0]  OP_END      = 8'h66;
    localparam logic [3:0]  OP_SHORT_HI = 4'h7;

    localparam logic [15:0] LIMIT_RESET = 16'd2048;
    localparam logic [5:0]  SIL_LAST    = 6'd33;

    // samples/245 as (x * RECIP_245) >> RECIP_SHIFT, exact for x below 120700
    localparam logic [16:0] RECIP_245   = 17'd68479;
    localparam int          RECIP_SHIFT = 24;
    localparam logic [16:0] ROUND_ADD   = 17'd122;

    localparam logic [7:0]  KEY_REG     = 8'h28;
    localparam logic [7:0]  TL_BASE     = 8'h40;
    localparam logic [7:0]  TL_MAX      = 8'd127;

    // One step of the silencing run: key-offs, total-level max, tone mutes.
    function automatic res_t silence_item(input logic [5:0] step);
        res_t        r;
        logic [5:0]  k;
        logic [3:0]  k2;
        logic [1:0]  idx;
        r  = '{kind: KIND_FM, port: 1'b0, rd: 8'h00, wv: 8'h00};
        k  = step - 6'd6;
        k2 = 4'd0;
        idx = 2'd0;
        if (step < 6'd6) begin
            r.rd = KEY_REG;
            r.wv = (step < 6'd3) ? {5'd0, step[2:0]} : {5'd0, step[2:0] + 3'd1};
        end else if (step < 6'd30) begin
            r.port = (k >= 6'd12);
            k2     = r.port ? 4'(k - 6'd12) : k[3:0];
            r.rd   = TL_BASE + {6'd0, k2[3:2]} + {4'd0, k2[0], k2[1], 2'b00};
            r.wv   = TL_MAX;
        end else begin
            idx    = 2'(step - 6'd30);
            r.kind = KIND_TONE;
            r.rd   = {1'b1, idx, 5'h1f};
        end
        return r;
    endfunction

endpackage

@@ rtl/core/vgm_command_stream_player.sv @@
// Top level of the VGM command stream player.

// VGM command stream player. Each input item carries a command on s_tuser
// (stream byte, tick, start, stop, enable, disable, end of data) and a stream
// byte plus loop flag on s_tdata. Every item yields one result item, or the
// 34-item silencing run (key-off, max attenuation, tone mutes) when playback
// is stopped. All decode work happens in one pass between the state/input
// side and the result register: an item that yields a single result is taken
// every cycle, including while the previous result sits in the result
// register, as long as the sink takes it in the same cycle. A stop holds
// s_tready low until the rest of the silencing run has been loaded into the
// result register. The status fields of m_tdata (awaiting, playing, wait left)
// show the state after the item that produced the result. Wait opcodes are
// converted to timer ticks as (samples+122)/245, minimum one; the 0x61 wait
// uses one 17x17 reciprocal multiply. command_limit is written through cfg_wr_en /
// cfg_wr_data while idle; a value of zero acts as one.
module vgm_command_stream_player (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,   // command_limit
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,       // [7:0] byte_value, [8] loop_present, rest zero
    input  logic [2:0]  s_tuser,       // [2:0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,       // [0] fm_port, [8:1] reg_or_data, [16:9] write_value,
                                       // [17] awaiting_bytes, [18] playing_now,
                                       // [27:19] wait_left, rest zero
    output logic [1:0]  m_tuser,       // [1:0] result_kind
    output logic        m_tlast
);
    import vcsp_pkg::*;

    // playback state
    logic        playing_reg, playing_next;
    logic        enabled_reg, enabled_next;
    logic        loop_reg, loop_next;
    logic [8:0]  wait_reg, wait_next;
    logic [1:0]  phase_reg, phase_next;
    logic [7:0]  opcode_reg, opcode_next;
    logic [7:0]  operand_reg, operand_next;
    logic [15:0] csw_reg, csw_next;
    logic [15:0] limit_reg;

    // result register and silencing sequencer
    logic        m_valid_reg, m_valid_next;
    res_t        res_reg, res_next;
    logic        last_reg, last_next;
    logic        sil_active_reg, sil_active_next;
    logic [5:0]  sil_step_reg, sil_step_next;

    logic        out_free, accept, awaiting;
    logic        do_stop;
    res_t        emit_res;
    cmd_t        cmd;
    logic [7:0]  b;
    logic [15:0] limit_eff;
    logic [16:0] samples;
    logic [33:0] prod;
    logic [8:0]  long_ticks;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = !sil_active_reg && out_free;
    assign accept   = s_tvalid && s_tready;
    assign awaiting = playing_reg && enabled_reg && (wait_reg == 9'd0);

    assign cmd       = cmd_t'(s_tuser);
    assign b         = s_tdata[7:0];
    assign limit_eff = (limit_reg == 16'd0) ? 16'd1 : limit_reg;

    // 0x61 wait: {hi, lo} samples, rounded to ticks by reciprocal multiply
    assign samples    = {1'b0, b, operand_reg} + ROUND_ADD;
    assign prod       = 34'(samples) * 34'(RECIP_245);
    assign long_ticks = prod[RECIP_SHIFT +: 9];

    // command decode and state update
    always_comb begin
        playing_next = playing_reg;
        enabled_next = enabled_reg;
        loop_next    = loop_reg;
        wait_next    = wait_reg;
        phase_next   = phase_reg;
        opcode_next  = opcode_reg;
        operand_next = operand_reg;
        csw_next     = csw_reg;
        do_stop      = 1'b0;
        emit_res     = '{kind: KIND_STATUS, port: 1'b0, rd: 8'h00, wv: 8'h00};
        case (cmd)
            CMD_BYTE: begin
                if (awaiting) begin
                    if (phase_reg == 2'd0) begin
                        if (csw_reg >= limit_eff) begin
                            do_stop = 1'b1;
                        end else begin
                            opcode_next = b;
                            if (b == OP_TONE || b == OP_FM0 || b == OP_FM1 || b == OP_WAIT) begin
                                phase_next = 2'd1;
                            end else if (b == OP_WAIT_NTSC) begin
                                wait_next = 9'd3;
                                csw_next  = 16'd0;
                            end else if (b == OP_WAIT_PAL) begin
                                wait_next = 9'd4;
                                csw_next  = 16'd0;
                            end else if (b == OP_END) begin
                                if (!loop_reg) begin
                                    do_stop = 1'b1;
                                end else begin
                                    emit_res.kind = KIND_REWIND;
                                    if (csw_reg != 16'hffff) csw_next = csw_reg + 16'd1;
                                end
                            end else if (b[7:4] == OP_SHORT_HI) begin
                                // at most 16 samples: always rounds to the one-tick minimum
                                wait_next = 9'd1;
                                csw_next  = 16'd0;
                            end else begin
                                do_stop = 1'b1;
                            end
                        end
                    end else if (phase_reg == 2'd1) begin
                        if (opcode_reg == OP_TONE) begin
                            emit_res.kind = KIND_TONE;
                            emit_res.rd   = b;
                            phase_next    = 2'd0;
                            if (csw_reg != 16'hffff) csw_next = csw_reg + 16'd1;
                        end else begin
                            operand_next = b;
                            phase_next   = 2'd2;
                        end
                    end else begin
                        phase_next = 2'd0;
                        if (opcode_reg == OP_WAIT) begin
                            wait_next = (long_ticks == 9'd0) ? 9'd1 : long_ticks;
                            csw_next  = 16'd0;
                        end else begin
                            emit_res.kind = KIND_FM;
                            emit_res.port = opcode_reg[0];
                            emit_res.rd   = operand_reg;
                            emit_res.wv   = b;
                            if (csw_reg != 16'hffff) csw_next = csw_reg + 16'd1;
                        end
                    end
                end
            end
            CMD_TICK: begin
                if (playing_reg && enabled_reg) begin
                    if (wait_reg != 9'd0) wait_next = wait_reg - 9'd1;
                    if (wait_reg <= 9'd1) csw_next = 16'd0;
                end
            end
            CMD_START:   do_stop = 1'b1;
            CMD_STOP:    do_stop = 1'b1;
            CMD_ENABLE:  enabled_next = 1'b1;
            CMD_DISABLE: begin
                enabled_next = 1'b0;
                do_stop      = 1'b1;
            end
            CMD_EOD:     do_stop = awaiting;
            default:     ;
        endcase
        if (do_stop) begin
            playing_next = 1'b0;
            loop_next    = 1'b0;
            wait_next    = 9'd0;
            phase_next   = 2'd0;
            csw_next     = 16'd0;
        end
        if (cmd == CMD_START && enabled_reg) begin
            playing_next = 1'b1;
            loop_next    = s_tdata[8];
        end
    end

    // result register loading: silencing run steps, or one result per item
    always_comb begin
        m_valid_next    = m_valid_reg;
        res_next        = res_reg;
        last_next       = last_reg;
        sil_active_next = sil_active_reg;
        sil_step_next   = sil_step_reg;
        if (sil_active_reg) begin
            if (out_free) begin
                m_valid_next  = 1'b1;
                res_next      = silence_item(sil_step_reg);
                last_next     = (sil_step_reg == SIL_LAST);
                sil_step_next = sil_step_reg + 6'd1;
                if (sil_step_reg == SIL_LAST) begin
                    sil_active_next = 1'b0;
                    sil_step_next   = 6'd0;
                end
            end
        end else if (accept) begin
            m_valid_next = 1'b1;
            if (do_stop) begin
                res_next        = silence_item(6'd0);
                last_next       = 1'b0;
                sil_active_next = 1'b1;
                sil_step_next   = 6'd1;
            end else begin
                res_next  = emit_res;
                last_next = 1'b1;
            end
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            playing_reg    <= 1'b0;
            enabled_reg    <= 1'b1;
            loop_reg       <= 1'b0;
            wait_reg       <= 9'd0;
            phase_reg      <= 2'd0;
            opcode_reg     <= 8'h00;
            operand_reg    <= 8'h00;
            csw_reg        <= 16'd0;
            limit_reg      <= LIMIT_RESET;
            m_valid_reg    <= 1'b0;
            sil_active_reg <= 1'b0;
            sil_step_reg   <= 6'd0;
        end else begin
            if (accept) begin
                playing_reg <= playing_next;
                enabled_reg <= enabled_next;
                loop_reg    <= loop_next;
                wait_reg    <= wait_next;
                phase_reg   <= phase_next;
                opcode_reg  <= opcode_next;
                operand_reg <= operand_next;
                csw_reg     <= csw_next;
            end
            if (cfg_wr_en) limit_reg <= cfg_wr_data;
            m_valid_reg    <= m_valid_next;
            sil_active_reg <= sil_active_next;
            sil_step_reg   <= sil_step_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg  <= res_next;
        last_reg <= last_next;
    end

    // Status fields follow the state registers, which change only on the
    // same edges that load a new result, so they always match m_tdata.
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = res_reg.kind;
    assign m_tlast  = last_reg;
    assign m_tdata  = {4'd0, wait_reg, playing_reg, awaiting,
                       res_reg.wv, res_reg.rd, res_reg.port};

endmodule

@@ rtl/core/vcsp_checker.sv @@
// Port-level checker for the VGM command stream player, bound to the top level.
`include "assert_macros.svh"

module vcsp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);
    import vcsp_pkg::*;

    // a stalled result holds
    `ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // mid-run of the silencing sequence no new item is taken
    `ASSERT_IMPL(a_run_blocks, aclk, aresetn, m_tvalid && !m_tlast, !s_tready)

    // silencing results are chip writes with no wait pending
    `ASSERT_IMPL(a_run_kind, aclk, aresetn, m_tvalid && !m_tlast,
                 (m_tuser == KIND_FM || m_tuser == KIND_TONE) && (m_tdata[27:19] == 9'd0))

    // awaiting bytes only while playing with no wait left
    `ASSERT_IMPL(a_await, aclk, aresetn, m_tvalid && m_tdata[17],
                 m_tdata[18] && (m_tdata[27:19] == 9'd0))

endmodule

bind vgm_command_stream_player vcsp_checker u_vcsp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
